### hw/rtl/fav_pkg.sv
// Package for the force admittance velocity step block.
// Holds the controller states, command and status structs, register codes and constants.
// Has no dependencies; every other file of the block imports it.
package fav_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_FUN,
        S_MUL1,
        S_SHIFT,
        S_MUL2,
        S_DIVZ,
        S_WAITZ,
        S_DIVA,
        S_WAITA,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        REG_TARGET = 3'd0,
        REG_IMASS  = 3'd1,
        REG_DAMP   = 3'd2,
        REG_LIMIT  = 3'd3,
        REG_DBAND  = 3'd4,
        REG_SETTLE = 3'd5
    } t_reg_idx;

    typedef enum logic {
        DIV_SEL_Z = 1'b0,
        DIV_SEL_A = 1'b1
    } t_div_sel;

    typedef struct packed {
        logic signed [17:0] target_force;
        logic [16:0]        inverse_mass;
        logic [9:0]         damping;
        logic [19:0]        speed_limit;
        logic [16:0]        speed_deadband;
        logic [16:0]        settle_band;
    } t_cfg;

    typedef struct packed {
        logic     load;
        logic     err;
        logic     fun;
        logic     mul1;
        logic     shift;
        logic     mul2;
        logic     div_go;
        t_div_sel div_sel;
        logic     save_dv;
        logic     fin;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

    localparam t_cfg CFG_RESET = '{
        target_force:   18'sd10000,
        inverse_mass:   17'd4369,
        damping:        10'd20,
        speed_limit:    20'd50000,
        speed_deadband: 17'd1000,
        settle_band:    17'd4000
    };

    // Rounded-up reciprocals: 2^57 / 15625 after a shift by 6, and 2^36 / 125 after a
    // shift by 3, which give the exact truncated quotients by 1000000 and by 1000.
    localparam logic [43:0] RECIP_Z       = 44'd9223372036855;
    localparam logic [43:0] RECIP_A       = 44'd549755814;
    localparam logic [1:0]  DIV_LAST_STEP = 2'd3;

    localparam logic signed [31:0] APPROACH_SPEED = -32'sd20000;
    localparam logic signed [31:0] SWEEP_SPEED    = 32'sd1000000;
    localparam logic signed [31:0] ACCEL_MAX      = 32'sd2000000;

    localparam logic [6:0] SETTLE_TICKS    = 7'd100;
    localparam logic [7:0] SWEEP_LAST      = 8'd199;
    localparam logic [7:0] SWEEP_POS_END   = 8'd80;
    localparam logic [7:0] SWEEP_PAUSE_END = 8'd100;
    localparam logic [7:0] SWEEP_NEG_END   = 8'd180;

endpackage

### hw/rtl/fav_div.sv
// Divider of a magnitude by one of two fixed divisors using reciprocal multiplication.
// A 22 by 22 bit multiplier accumulates four partial products, one per cycle.
// Depends on fav_pkg.
module fav_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  fav_pkg::t_div_sel i_sel,
    input  logic [48:0]       i_mag,
    output logic              o_done,
    output logic [29:0]       o_quot
);
    import fav_pkg::*;

    logic [43:0] r_x;
    logic [43:0] r_recip;
    logic [87:0] r_acc;
    t_div_sel    r_sel;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [21:0] w_opa;
    logic [21:0] w_opb;
    logic [43:0] w_prod;
    logic [87:0] w_term;

    assign w_opa  = r_step[1] ? r_x[43:22] : r_x[21:0];
    assign w_opb  = r_step[0] ? r_recip[43:22] : r_recip[21:0];
    assign w_prod = w_opa * w_opb;

    always_comb begin
        case (r_step)
            2'd0:    w_term = {44'd0, w_prod};
            2'd3:    w_term = {w_prod, 44'd0};
            default: w_term = {22'd0, w_prod, 22'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == DIV_LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sel <= i_sel;
            r_acc <= '0;
            if (i_sel == DIV_SEL_Z) begin
                r_x     <= {1'b0, i_mag[48:6]};
                r_recip <= RECIP_Z;
            end else begin
                r_x     <= {15'd0, i_mag[31:3]};
                r_recip <= RECIP_A;
            end
        end else if (r_busy) begin
            r_acc <= r_acc + w_term;
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_sel == DIV_SEL_Z) ? r_acc[86:57] : r_acc[65:36];

endmodule

### hw/rtl/fav_datapath.sv
// Datapath: force error, admittance products, divisions, shaping and sweep state.
// Each step is enabled by the controller command struct; results go to an output register.
// Depends on fav_pkg and fav_div.
module fav_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fav_pkg::t_cmd      i_cmd,
    output fav_pkg::t_stat     o_stat,
    input  fav_pkg::t_cfg      i_cfg,
    input  logic [63:0]        i_tdata,
    output logic signed [20:0] o_z,
    output logic signed [20:0] o_y,
    output logic signed [21:0] o_acc,
    output logic               o_sweep
);
    import fav_pkg::*;

    function automatic logic signed [20:0] shape(input logic signed [31:0] v,
                                                 input logic [19:0] lim,
                                                 input logic [16:0] db);
        logic signed [31:0] mag;
        logic signed [31:0] lim_s;
        logic signed [31:0] res;
        mag   = (v < 0) ? -v : v;
        lim_s = $signed({12'd0, lim});
        res   = v;
        if (mag < $signed({15'd0, db})) res = 32'sd0;
        if (res > lim_s) res = lim_s;
        else if (res < -lim_s) res = -lim_s;
        return 21'(res);
    endfunction

    logic signed [19:0] r_force;
    logic signed [20:0] r_speed;
    logic [16:0]        r_dt;
    logic signed [20:0] r_err;
    logic signed [31:0] r_ds;
    logic signed [31:0] r_fun;
    logic signed [49:0] r_p1;
    logic signed [32:0] r_aum;
    logic signed [50:0] r_p2;
    logic signed [31:0] r_dv;
    logic [6:0]         r_count;
    logic [7:0]         r_phase;
    logic               r_contact;
    logic signed [20:0] r_z;
    logic signed [20:0] r_y;
    logic signed [21:0] r_acc;
    logic               r_sweep;

    logic signed [49:0] w_p1_adj;
    logic signed [50:0] w_p2_abs;
    logic signed [32:0] w_aum_abs;
    logic [48:0]        w_div_mag;
    logic [29:0]        w_quot;
    logic               w_div_done;
    logic signed [31:0] w_q32;
    logic signed [31:0] w_acc_s;
    logic signed [31:0] w_acc_sat;
    logic signed [31:0] w_z_raw;
    logic signed [31:0] w_y_raw;
    logic [20:0]        w_abs_err;
    logic [6:0]         w_count_next;
    logic               w_sweep;

    assign w_p1_adj  = r_p1 + (r_p1[49] ? 50'sd65535 : 50'sd0);
    assign w_p2_abs  = r_p2[50] ? -r_p2 : r_p2;
    assign w_aum_abs = r_aum[32] ? -r_aum : r_aum;
    assign w_div_mag = (i_cmd.div_sel == DIV_SEL_Z) ? w_p2_abs[48:0]
                                                    : {17'd0, w_aum_abs[31:0]};

    fav_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_sel   (i_cmd.div_sel),
        .i_mag   (w_div_mag),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_stat.div_done = w_div_done;
    assign w_q32 = $signed({2'b00, w_quot});

    always_comb begin
        w_acc_s = r_aum[32] ? -w_q32 : w_q32;
        if (w_acc_s > ACCEL_MAX) w_acc_sat = ACCEL_MAX;
        else if (w_acc_s < -ACCEL_MAX) w_acc_sat = -ACCEL_MAX;
        else w_acc_sat = w_acc_s;
    end

    always_comb begin
        w_abs_err = r_err[20] ? 21'(-r_err) : 21'(r_err);
        if ((w_abs_err < {4'd0, i_cfg.settle_band}) && (r_count <= SETTLE_TICKS)) begin
            w_count_next = r_count + 7'd1;
        end else begin
            w_count_next = r_count;
        end
        w_sweep = (w_count_next > SETTLE_TICKS);
        if (!w_sweep) w_y_raw = 32'sd0;
        else if (r_phase < SWEEP_POS_END) w_y_raw = SWEEP_SPEED;
        else if (r_phase < SWEEP_PAUSE_END) w_y_raw = 32'sd0;
        else if (r_phase < SWEEP_NEG_END) w_y_raw = -SWEEP_SPEED;
        else w_y_raw = 32'sd0;
        if ((r_force == 20'sd0) && !r_contact) w_z_raw = APPROACH_SPEED;
        else w_z_raw = 32'(r_speed) + r_dv;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_force <= i_tdata[19:0];
            r_speed <= i_tdata[40:20];
            r_dt    <= i_tdata[57:41];
        end
        if (i_cmd.err) begin
            r_err <= 21'(r_force) - 21'(i_cfg.target_force);
            r_ds  <= 32'($signed({1'b0, i_cfg.damping})) * 32'(r_speed);
        end
        if (i_cmd.fun) begin
            r_fun <= 32'(r_err) * 32'sd1000 - r_ds;
        end
        if (i_cmd.mul1) begin
            r_p1 <= 50'($signed({1'b0, i_cfg.inverse_mass})) * 50'(r_fun);
        end
        if (i_cmd.shift) begin
            r_aum <= 33'(w_p1_adj >>> 16);
        end
        if (i_cmd.mul2) begin
            r_p2 <= 51'(r_aum) * 51'($signed({1'b0, r_dt}));
        end
        if (i_cmd.save_dv) begin
            r_dv <= r_p2[50] ? -w_q32 : w_q32;
        end
        if (i_cmd.fin) begin
            r_z     <= shape(w_z_raw, i_cfg.speed_limit, i_cfg.speed_deadband);
            r_y     <= shape(w_y_raw, i_cfg.speed_limit, i_cfg.speed_deadband);
            r_acc   <= 22'(w_acc_sat);
            r_sweep <= w_sweep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_phase   <= '0;
            r_contact <= 1'b0;
        end else if (i_cmd.fin) begin
            r_count   <= w_count_next;
            r_contact <= r_contact | (r_force != 20'sd0);
            if (w_sweep) begin
                r_phase <= (r_phase == SWEEP_LAST) ? 8'd0 : r_phase + 8'd1;
            end
        end
    end

    assign o_z     = r_z;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
    assign o_sweep = r_sweep;

endmodule

### hw/rtl/fav_ctrl.sv
// Controller state machine that sequences the datapath steps for one transaction.
// Also owns the input ready and the output valid flag.
// Depends on fav_pkg.
module fav_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_m_tready,
    input  fav_pkg::t_stat i_stat,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    output fav_pkg::t_cmd  o_cmd
);
    import fav_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid & ~i_m_tready;
        o_cmd         = '0;
        o_cmd.div_sel = DIV_SEL_Z;
        o_s_tready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = S_FUN;
            end
            S_FUN: begin
                o_cmd.fun = 1'b1;
                n_state   = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_DIVZ;
            end
            S_DIVZ: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_WAITZ;
            end
            S_WAITZ: begin
                if (i_stat.div_done) begin
                    o_cmd.save_dv = 1'b1;
                    n_state       = S_DIVA;
                end
            end
            S_DIVA: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DIV_SEL_A;
                n_state       = S_WAITA;
            end
            S_WAITA: begin
                if (i_stat.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_valid || i_m_tready) begin
                    o_cmd.fin = 1'b1;
                    n_valid   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_valid;

endmodule

### hw/rtl/force_admittance_velocity_step.sv
// Top level of the force admittance velocity step block.
// Holds the configuration registers and APB port, and joins fav_ctrl and fav_datapath.
// Depends on fav_pkg, fav_ctrl and fav_datapath.
//
// Channel   Direction  Signals                              Content
// s_axis    in         tvalid, tready, tdata[63:0]          one control tick
// m_axis    out        tvalid, tready, tdata[71:0]          one command result
// apb       in/out     psel, penable, pwrite, paddr, ...    six config registers
//
// Six steps, two constant divisions by reciprocal multiplication (each a launch, four
// partial products and a done strobe) and a final step load the result. No new tick is
// accepted before the final step; the next one can be taken in the cycle after it. Reset
// is synchronous and active low; it restores register defaults and clears the settle
// count, sweep phase and contact flag. A result that waits in the output register does
// not block the next acceptance; only the final step waits for it to be taken.
module force_admittance_velocity_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [19:0] measured_force, [40:20] measured_speed, [57:41] elapsed_us
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [20:0] z_speed_cmd, [41:21] y_speed_cmd, [63:42] accel_out, [64] sweep_on
    output logic [71:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fav_pkg::*;

    t_cfg               r_cfg;
    t_cmd               w_cmd;
    t_stat              w_stat;
    t_reg_idx           w_idx;
    logic               w_wr;
    logic signed [20:0] w_z;
    logic signed [20:0] w_y;
    logic signed [21:0] w_acc;
    logic               w_sweep;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_TARGET: r_cfg.target_force   <= pwdata[17:0];
                REG_IMASS:  r_cfg.inverse_mass   <= pwdata[16:0];
                REG_DAMP:   r_cfg.damping        <= pwdata[9:0];
                REG_LIMIT:  r_cfg.speed_limit    <= pwdata[19:0];
                REG_DBAND:  r_cfg.speed_deadband <= pwdata[16:0];
                REG_SETTLE: r_cfg.settle_band    <= pwdata[16:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TARGET: prdata = 32'(r_cfg.target_force);
            REG_IMASS:  prdata = {15'd0, r_cfg.inverse_mass};
            REG_DAMP:   prdata = {22'd0, r_cfg.damping};
            REG_LIMIT:  prdata = {12'd0, r_cfg.speed_limit};
            REG_DBAND:  prdata = {15'd0, r_cfg.speed_deadband};
            REG_SETTLE: prdata = {15'd0, r_cfg.settle_band};
            default:    prdata = 32'd0;
        endcase
    end

    fav_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (w_stat),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    fav_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_cfg   (r_cfg),
        .i_tdata (s_axis_tdata),
        .o_z     (w_z),
        .o_y     (w_y),
        .o_acc   (w_acc),
        .o_sweep (w_sweep)
    );

    assign m_axis_tdata = {7'd0, w_sweep, w_acc, w_y, w_z};

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a transaction is in progress");

    a_no_div_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && w_cmd.div_go))
        else $error("divider started while the block is idle");

    a_fin_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fin |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result written over one not yet taken");

    a_fin_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fin |=> m_axis_tvalid)
        else $error("finished result not presented");

endmodule

### tb/tb_force_admittance_velocity_step.sv
// Self-checking testbench for force_admittance_velocity_step: a directed table, then random ticks
// under several register settings, each checked against a typed value or a behavioral predictor.
// Depends on fav_pkg and the force_admittance_velocity_step RTL.
`timescale 1ns / 1ps

module tb_force_admittance_velocity_step;
    import fav_pkg::*;

    typedef struct packed {
        logic signed [20:0] z_speed;
        logic signed [20:0] y_speed;
        logic signed [21:0] accel;
        logic               sweep_on;
    } t_cmd_result;

    typedef struct packed {
        logic [19:0] force_mn;
        logic [20:0] speed_ums;
        logic [16:0] dt_us;
        logic        typed;
        t_cmd_result exp;
    } t_tick_row;

    localparam int NUM_DIRECTED = 19;
    localparam int NUM_PHASES = 8;
    localparam int TICKS_PER_PHASE = 160;
    localparam int DRAIN_CYCLES = 100;

    localparam t_tick_row DIRECTED_TICKS [0:NUM_DIRECTED-1] = '{
        '{20'd0, 21'd0, 17'd0, 1'b1, '{-21'sd20000, 21'sd0, -22'sd666, 1'b0}},
        '{20'd0, 21'd500000, 17'd100000, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{20'd10000, 21'd0, 17'd50000, 1'b1, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{20'd0, 21'd0, 17'd0, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{20'd10000, 21'h100000, 17'd0, 1'b1, '{-21'sd50000, 21'sd0, 22'sd1398, 1'b0}},
        '{20'd10000, 21'h0FFFFF, 17'd0, 1'b1, '{21'sd50000, 21'sd0, -22'sd1398, 1'b0}},
        '{20'h7FFFF, 21'd0, 17'd100000, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{20'h80000, 21'h0FFFFF, 17'h1FFFF, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{20'd10001, 21'd50, 17'd30000, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{20'd10000, 21'd999, 17'd0, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{20'd10000, -21'sd1000, 17'd0, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{20'd13999, 21'd0, 17'd1000, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{20'd14000, 21'd0, 17'd1000, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{20'd6001, 21'd0, 17'd1000, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{20'd6000, 21'd0, 17'd1000, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{-20'sd500000, -21'sd1000000, 17'd100000, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{20'sd500000, 21'sd1000000, 17'd1, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{20'hFFFFF, 21'h1FFFFF, 17'h15555, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}},
        '{20'h55555, 21'h0AAAAA, 17'h0AAAA, 1'b0, '{21'sd0, 21'sd0, 22'sd0, 1'b0}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the registers and of the settle, sweep and contact state.
    longint cfg_target = 10000;
    longint cfg_imass = 4369;
    longint cfg_damping = 20;
    longint cfg_limit = 50000;
    longint cfg_deadband = 1000;
    longint cfg_settle = 4000;
    int     settled_ticks = 0;
    int     sweep_step = 0;
    bit     contact_flag = 1'b0;

    t_cmd_result pending_cmds[$];
    int          mismatch_count = 0;
    bit          sink_eager = 1'b0;

    force_admittance_velocity_step dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        #(64'd10_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint clamp_with_deadband(input longint v);
        longint mag;
        mag = v < 0 ? -v : v;
        if (mag < cfg_deadband) v = 0;
        if (v > cfg_limit) v = cfg_limit;
        else if (v < -cfg_limit) v = -cfg_limit;
        return v;
    endfunction

    function automatic t_cmd_result predict_velocity_cmd(input logic [19:0] f_bits,
                                                         input logic [20:0] v_bits,
                                                         input logic [16:0] dt_bits);
        longint      force_mn, speed, dt, err, f_un, a_um, z, y, acc, abs_err;
        bit          sweep;
        t_cmd_result res;
        force_mn = $signed(f_bits);
        speed = $signed(v_bits);
        dt = dt_bits;
        err = force_mn - cfg_target;
        f_un = err * 1000 - cfg_damping * speed;
        a_um = (cfg_imass * f_un) / 65536;
        z = speed + (a_um * dt) / 1000000;
        acc = a_um / 1000;
        abs_err = err < 0 ? -err : err;
        y = 0;
        sweep = 1'b0;
        if (abs_err < cfg_settle && settled_ticks <= 100) settled_ticks++;
        if (settled_ticks > 100) begin
            sweep = 1'b1;
            if (sweep_step < 80) y = 1000000;
            else if (sweep_step < 100) y = 0;
            else if (sweep_step < 180) y = -1000000;
            else y = 0;
            sweep_step = (sweep_step + 1) % 200;
        end
        if (force_mn != 0) contact_flag = 1'b1;
        if (force_mn == 0 && !contact_flag) z = -20000;
        z = clamp_with_deadband(z);
        y = clamp_with_deadband(y);
        if (acc > 2000000) acc = 2000000;
        else if (acc < -2000000) acc = -2000000;
        res.z_speed = z[20:0];
        res.y_speed = y[20:0];
        res.accel = acc[21:0];
        res.sweep_on = sweep;
        return res;
    endfunction

    function automatic int pick_gap(input bit eager);
        int r;
        r = $urandom_range(0, 99);
        if (eager || r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TARGET: cfg_target = $signed(value[17:0]);
            REG_IMASS:  cfg_imass = value[16:0];
            REG_DAMP:   cfg_damping = value[9:0];
            REG_LIMIT:  cfg_limit = value[19:0];
            REG_DBAND:  cfg_deadband = value[16:0];
            REG_SETTLE: cfg_settle = value[16:0];
            default: ;
        endcase
    endtask

    task automatic write_registers(input logic [31:0] target, input logic [31:0] imass,
                                   input logic [31:0] damp, input logic [31:0] limit,
                                   input logic [31:0] dband, input logic [31:0] settle);
        apb_write(REG_TARGET, target);
        apb_write(REG_IMASS, imass);
        apb_write(REG_DAMP, damp);
        apb_write(REG_LIMIT, limit);
        apb_write(REG_DBAND, dband);
        apb_write(REG_SETTLE, settle);
    endtask

    task automatic send_tick(input logic [19:0] f_bits, input logic [20:0] v_bits,
                             input logic [16:0] dt_bits, input bit typed,
                             input t_cmd_result typed_exp, input bit eager);
        int          gap;
        t_cmd_result predicted;
        gap = pick_gap(eager);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, dt_bits, v_bits, f_bits};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_velocity_cmd(f_bits, v_bits, dt_bits);
        pending_cmds.push_back(typed ? typed_exp : predicted);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    // Result side: check every accepted transaction, then choose the next ready value.
    initial begin
        int          stall_left;
        t_cmd_result got;
        t_cmd_result want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.z_speed = m_axis_tdata[20:0];
                got.y_speed = m_axis_tdata[41:21];
                got.accel = m_axis_tdata[63:42];
                got.sweep_on = m_axis_tdata[64];
                if (pending_cmds.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result: z=%0d y=%0d accel=%0d sweep=%0b",
                                 got.z_speed, got.y_speed, got.accel, got.sweep_on);
                end else begin
                    want = pending_cmds.pop_front();
                    if (got.z_speed !== want.z_speed || got.y_speed !== want.y_speed ||
                        got.accel !== want.accel || got.sweep_on !== want.sweep_on) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Mismatch: expected z=%0d y=%0d accel=%0d sweep=%0b, %s",
                                     want.z_speed, want.y_speed, want.accel, want.sweep_on,
                                     $sformatf("got z=%0d y=%0d accel=%0d sweep=%0b",
                                               got.z_speed, got.y_speed, got.accel,
                                               got.sweep_on));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                stall_left = pick_gap(sink_eager);
                m_axis_tready <= (stall_left == 0);
            end
        end
    end

    initial begin
        int          phase;
        int          n;
        int          kind;
        int          span;
        bit          eager;
        longint      f_val;
        longint      v_val;
        longint      dt_val;
        t_cmd_result no_exp;
        no_exp = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < NUM_DIRECTED; n++) begin
            send_tick(DIRECTED_TICKS[n].force_mn, DIRECTED_TICKS[n].speed_ums,
                      DIRECTED_TICKS[n].dt_us, DIRECTED_TICKS[n].typed,
                      DIRECTED_TICKS[n].exp, 1'b0);
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            s_axis_tvalid <= 1'b0;
            wait_drained();
            case (phase)
                0: ;
                1: write_registers(-32'sd100000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
                2: write_registers(32'd100000, 32'd65536, 32'd1000, 32'd1000000,
                                   32'd100000, 32'd100000);
                3: write_registers(32'h20000, 32'h1FFFF, 32'h3FF, 32'hFFFFF,
                                   32'h1FFFF, 32'h1FFFF);
                default: begin
                    write_registers($urandom_range(0, 200000) - 100000,
                                    $urandom_range(0, 3) == 0 ? $urandom_range(1, 64)
                                                              : $urandom_range(1, 65536),
                                    $urandom_range(0, 1000),
                                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 5000)
                                                              : $urandom_range(0, 1000000),
                                    $urandom_range(0, 1) ? $urandom_range(0, 5000)
                                                         : $urandom_range(0, 100000),
                                    $urandom_range(0, 100000));
                end
            endcase
            eager = ($urandom_range(0, 3) == 0);
            sink_eager = ($urandom_range(0, 3) == 0);
            for (n = 0; n < TICKS_PER_PHASE; n++) begin
                kind = $urandom_range(0, 99);
                if (kind < (phase == 0 ? 92 : 65)) begin
                    span = int'(cfg_settle) + int'(cfg_settle) / 8 + 1;
                    f_val = cfg_target + $urandom_range(0, 2 * span) - span;
                    v_val = $urandom_range(0, 1) ? $urandom_range(0, 4000) - 2000
                                                 : $urandom_range(0, 120000) - 60000;
                    dt_val = $urandom_range(0, 100000);
                end else if (kind < 88) begin
                    f_val = $urandom_range(0, 1000000) - 500000;
                    v_val = $urandom_range(0, 2000000) - 1000000;
                    dt_val = $urandom_range(0, 100000);
                end else begin
                    f_val = $urandom;
                    v_val = $urandom;
                    dt_val = $urandom;
                end
                send_tick(f_val[19:0], v_val[20:0], dt_val[16:0], 1'b0, no_exp, eager);
            end
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_cmds.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
